/* design/gray_to_ascii_symbol_sampler_core_assert.svh */
// assertion macros for the gray-to-symbol sampler
`ifndef GRAY_TO_ASCII_SYMBOL_SAMPLER_CORE_ASSERT_SVH
`define GRAY_TO_ASCII_SYMBOL_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, skipped during reset
`define GTAS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtas assertion failed");

// next-cycle implication, skipped during reset
`define GTAS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtas assertion failed");

`endif

/* design/gtas_pkg.sv */
package gtas_pkg;

  // fixed field widths
  localparam int PIXEL_W    = 8;
  localparam int SYMBOL_W   = 8;
  localparam int NSYM_W     = 5;
  localparam int STEP_W     = 12;
  localparam int WORD_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NEFF_W     = 6;

  // symbol table held in three words of eight bytes
  localparam int TABLE_ENTRIES = 24;
  localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int BYTES_PER_WORD = WORD_W / SYMBOL_W;

  // parameter defaults
  localparam int MAX_SYMBOLS_DEF = 24;
  localparam int COUNT_BITS_DEF  = 12;

  // restoring divider runs one quotient bit per cycle
  localparam int DIV_STEPS = PIXEL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // 255 / n for n = 0..32, entry zero unused
  localparam logic [PIXEL_W-1:0] STEP_TABLE [0:32] = '{
    8'd1,   8'd255, 8'd127, 8'd85,  8'd63,  8'd51,  8'd42,  8'd36,
    8'd31,  8'd28,  8'd25,  8'd23,  8'd21,  8'd19,  8'd18,  8'd17,
    8'd15,  8'd15,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,
    8'd10,  8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,
    8'd7
  };

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SYMBOLS      = 3'd0,
    REG_ROW_STEP         = 3'd1,
    REG_COL_STEP         = 3'd2,
    REG_TEXT_ROWS        = 3'd3,
    REG_TEXT_COLS        = 3'd4,
    REG_SYMBOL_WORD_LOW  = 3'd5,
    REG_SYMBOL_WORD_MID  = 3'd6,
    REG_SYMBOL_WORD_HIGH = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [NSYM_W-1:0] num_symbols;
    logic [STEP_W-1:0] row_step;
    logic [STEP_W-1:0] col_step;
    logic [STEP_W-1:0] text_rows;
    logic [STEP_W-1:0] text_cols;
    logic [WORD_W-1:0] symbol_word_low;
    logic [WORD_W-1:0] symbol_word_mid;
    logic [WORD_W-1:0] symbol_word_high;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

/* design/gtas_regs.sv */
module gtas_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gtas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gtas_pkg::WORD_W-1:0]        cfg_data,
  output gtas_pkg::cfg_t                     cfg
);

  // register file, written one register per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_symbols      <= gtas_pkg::NSYM_W'(1);
      cfg.row_step         <= gtas_pkg::STEP_W'(1);
      cfg.col_step         <= gtas_pkg::STEP_W'(1);
      cfg.text_rows        <= gtas_pkg::STEP_W'(1);
      cfg.text_cols        <= gtas_pkg::STEP_W'(1);
      cfg.symbol_word_low  <= '0;
      cfg.symbol_word_mid  <= '0;
      cfg.symbol_word_high <= '0;
    end else if (cfg_we) begin
      unique case (gtas_pkg::cfg_reg_t'(cfg_index))
        gtas_pkg::REG_NUM_SYMBOLS:
          cfg.num_symbols <= cfg_data[gtas_pkg::NSYM_W-1:0];
        gtas_pkg::REG_ROW_STEP:         cfg.row_step  <= cfg_data[gtas_pkg::STEP_W-1:0];
        gtas_pkg::REG_COL_STEP:         cfg.col_step  <= cfg_data[gtas_pkg::STEP_W-1:0];
        gtas_pkg::REG_TEXT_ROWS:        cfg.text_rows <= cfg_data[gtas_pkg::STEP_W-1:0];
        gtas_pkg::REG_TEXT_COLS:        cfg.text_cols <= cfg_data[gtas_pkg::STEP_W-1:0];
        gtas_pkg::REG_SYMBOL_WORD_LOW:  cfg.symbol_word_low  <= cfg_data;
        gtas_pkg::REG_SYMBOL_WORD_MID:  cfg.symbol_word_mid  <= cfg_data;
        gtas_pkg::REG_SYMBOL_WORD_HIGH: cfg.symbol_word_high <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/gtas_ctrl.sv */
module gtas_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gtas_pkg::dp_cmd_t       cmd,
  input  gtas_pkg::dp_status_t    status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;
  logic   out_free;

  // output slot is free when empty or being emptied this cycle
  assign out_free  = !out_full || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;

  // sequencing of one item: accept, divide, hand to output register
  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output occupancy
  always_comb begin
    if (cmd.load_out) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

/* design/gtas_dp.sv */
module gtas_dp #(
  parameter int MAX_SYMBOLS = gtas_pkg::MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = gtas_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gtas_pkg::cfg_t                  cfg,
  input  gtas_pkg::dp_cmd_t               cmd,
  output gtas_pkg::dp_status_t            status,
  input  logic [gtas_pkg::PIXEL_W-1:0]    pixel,
  input  logic                            start_of_frame,
  input  logic                            end_of_line,
  output logic [gtas_pkg::SYMBOL_W-1:0]   symbol,
  output logic                            sampled,
  output logic                            end_of_text_row
);

  localparam int CMP_W = ((COUNT_BITS > gtas_pkg::STEP_W) ? COUNT_BITS : gtas_pkg::STEP_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int PW = gtas_pkg::PIXEL_W;

  // sampling counters
  logic [COUNT_BITS-1:0] row_phase, row_phase_next;
  logic [COUNT_BITS-1:0] text_row_index, text_row_index_next;
  logic [COUNT_BITS-1:0] col_phase, col_phase_next;
  logic [COUNT_BITS-1:0] text_col_index, text_col_index_next;
  logic [COUNT_BITS-1:0] row_phase_cur, text_row_index_cur;
  logic [COUNT_BITS-1:0] col_phase_cur, text_col_index_cur;
  logic [gtas_pkg::STEP_W-1:0] row_s, col_s;
  logic row_wrap, col_wrap;
  logic smp, eotr;

  // item flags held while the divider runs
  logic item_sampled;
  logic item_eotr;

  // divider registers
  logic [PW-1:0]                  quot, quot_next;
  logic [PW-1:0]                  rem, rem_next;
  logic [PW-1:0]                  divisor;
  logic [gtas_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [PW:0]                    trial;

  // symbol selection
  logic [gtas_pkg::NEFF_W-1:0]     n_eff;
  logic [PW-1:0]                   idx;
  logic [gtas_pkg::SYMBOL_W-1:0]   table_bytes [gtas_pkg::TABLE_ENTRIES];
  logic [gtas_pkg::SYMBOL_W-1:0]   code;

  // start of frame clears the counters before judging the pixel
  assign row_phase_cur      = start_of_frame ? '0 : row_phase;
  assign text_row_index_cur = start_of_frame ? '0 : text_row_index;
  assign col_phase_cur      = start_of_frame ? '0 : col_phase;
  assign text_col_index_cur = start_of_frame ? '0 : text_col_index;

  assign smp = (row_phase_cur == '0) && (col_phase_cur == '0) &&
               (CMP_W'(text_row_index_cur) < CMP_W'(cfg.text_rows)) &&
               (CMP_W'(text_col_index_cur) < CMP_W'(cfg.text_cols));
  assign eotr = smp &&
                (CMP_W'(text_col_index_cur) + CMP_W'(1) == CMP_W'(cfg.text_cols));

  // zero step counts as one
  assign row_s = (cfg.row_step == '0) ? gtas_pkg::STEP_W'(1) : cfg.row_step;
  assign col_s = (cfg.col_step == '0) ? gtas_pkg::STEP_W'(1) : cfg.col_step;

  assign row_wrap = (CMP_W'(row_phase_cur) + CMP_W'(1) >= CMP_W'(row_s)) ||
                    (row_phase_cur == CNT_MAX);
  assign col_wrap = (CMP_W'(col_phase_cur) + CMP_W'(1) >= CMP_W'(col_s)) ||
                    (col_phase_cur == CNT_MAX);

  // counter advance: end of line steps the rows, otherwise the columns
  always_comb begin
    row_phase_next      = row_phase_cur;
    text_row_index_next = text_row_index_cur;
    col_phase_next      = col_phase_cur;
    text_col_index_next = text_col_index_cur;
    if (end_of_line) begin
      col_phase_next      = '0;
      text_col_index_next = '0;
      if (row_wrap) begin
        row_phase_next = '0;
        if (text_row_index_cur != CNT_MAX) begin
          text_row_index_next = text_row_index_cur + COUNT_BITS'(1);
        end
      end else begin
        row_phase_next = row_phase_cur + COUNT_BITS'(1);
      end
    end else begin
      if (col_wrap) begin
        col_phase_next = '0;
        if (text_col_index_cur != CNT_MAX) begin
          text_col_index_next = text_col_index_cur + COUNT_BITS'(1);
        end
      end else begin
        col_phase_next = col_phase_cur + COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_phase      <= '0;
      text_row_index <= '0;
      col_phase      <= '0;
      text_col_index <= '0;
    end else if (cmd.start) begin
      row_phase      <= row_phase_next;
      text_row_index <= text_row_index_next;
      col_phase      <= col_phase_next;
      text_col_index <= text_col_index_next;
    end
  end

  // effective symbol count, clamped to one and to MAX_SYMBOLS
  always_comb begin
    if (cfg.num_symbols == '0) begin
      n_eff = gtas_pkg::NEFF_W'(1);
    end else if (gtas_pkg::NEFF_W'(cfg.num_symbols) > gtas_pkg::NEFF_W'(MAX_SYMBOLS)) begin
      n_eff = gtas_pkg::NEFF_W'(MAX_SYMBOLS);
    end else begin
      n_eff = gtas_pkg::NEFF_W'(cfg.num_symbols);
    end
  end

  // one restoring step: shift in the next dividend bit and try to subtract
  assign trial = {rem, quot[PW-1]} - {1'b0, divisor};

  always_comb begin
    quot_next = quot;
    rem_next  = rem;
    if (cmd.step) begin
      if (!trial[PW]) begin
        rem_next  = trial[PW-1:0];
        quot_next = {quot[PW-2:0], 1'b1};
      end else begin
        rem_next  = {rem[PW-2:0], quot[PW-1]};
        quot_next = {quot[PW-2:0], 1'b0};
      end
    end
  end

  assign status.div_last = (div_cnt == gtas_pkg::DIV_CNT_W'(gtas_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quot         <= pixel;
      rem          <= '0;
      divisor      <= gtas_pkg::STEP_TABLE[n_eff];
      div_cnt      <= '0;
      item_sampled <= smp;
      item_eotr    <= eotr;
    end else begin
      quot <= quot_next;
      rem  <= rem_next;
      if (cmd.step) begin
        div_cnt <= div_cnt + gtas_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // clamp the quotient to the last symbol and look up its code
  assign idx = (quot_next >= PW'(n_eff)) ? PW'(n_eff) - PW'(1) : quot_next;

  always_comb begin
    for (int b = 0; b < gtas_pkg::BYTES_PER_WORD; b++) begin
      table_bytes[b] = cfg.symbol_word_low[b*gtas_pkg::SYMBOL_W +: gtas_pkg::SYMBOL_W];
      table_bytes[b + gtas_pkg::BYTES_PER_WORD] =
        cfg.symbol_word_mid[b*gtas_pkg::SYMBOL_W +: gtas_pkg::SYMBOL_W];
      table_bytes[b + 2*gtas_pkg::BYTES_PER_WORD] =
        cfg.symbol_word_high[b*gtas_pkg::SYMBOL_W +: gtas_pkg::SYMBOL_W];
    end
  end

  assign code = (idx < PW'(gtas_pkg::TABLE_ENTRIES)) ?
                table_bytes[idx[gtas_pkg::TABLE_IDX_W-1:0]] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      symbol          <= code;
      sampled         <= item_sampled;
      end_of_text_row <= item_eotr;
    end
  end

endmodule

/* design/gray_to_ascii_symbol_sampler_core.sv */
// Gray pixel to symbol mapper with a text-grid sampler.
// Input channel: pixel, start_of_frame, end_of_line under in_valid/in_ready,
// pixels in raster order. Output channel: symbol, sampled, end_of_text_row
// under out_valid/out_ready, exactly one result per pixel, in order.
// Configuration: write cfg_data into register cfg_index when cfg_we is high;
// write only while no pixel is in flight.
// Flow: a taken pixel loads the divider, which then runs all its steps; the
// result then enters the output register. The block holds one pixel at a
// time; the quotient of pixel over the symbol step comes from a restoring
// divider that yields one bit per cycle, and no new pixel is taken until
// the result has entered the output register.
// The next pixel is taken while a finished result still waits at the output.
// Stall: if out_ready is low, the result stays in the output register and a
// newly computed one waits in the divider; in_ready stays low meanwhile.
// Reset: counts and steps return to one, table words to zero, sampling
// counters to zero, and both channels go empty.
module gray_to_ascii_symbol_sampler_core #(
  parameter int MAX_SYMBOLS = gtas_pkg::MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = gtas_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gtas_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gtas_pkg::WORD_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gtas_pkg::PIXEL_W-1:0]      pixel,
  input  logic                              start_of_frame,
  input  logic                              end_of_line,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gtas_pkg::SYMBOL_W-1:0]     symbol,
  output logic                              sampled,
  output logic                              end_of_text_row
);

`include "gray_to_ascii_symbol_sampler_core_assert.svh"

  gtas_pkg::cfg_t       cfg;
  gtas_pkg::dp_cmd_t    cmd;
  gtas_pkg::dp_status_t status;

  // configuration registers
  gtas_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencing
  gtas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // counters, divider and symbol lookup
  gtas_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .pixel           (pixel),
    .start_of_frame  (start_of_frame),
    .end_of_line     (end_of_line),
    .symbol          (symbol),
    .sampled         (sampled),
    .end_of_text_row (end_of_text_row)
  );

  // one pixel in flight: no second transfer right after a taken one
  `GTAS_ASSERT_NXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a text row end is always a sampled position
  `GTAS_ASSERT_IMP(a_eotr_sampled, clk, rst, out_valid && !sampled, !end_of_text_row)

  // the output register is not reloaded in the cycle after a pixel is taken
  `GTAS_ASSERT_NXT(a_out_hold, clk, rst, in_valid && in_ready, !out_valid || $stable(symbol))

endmodule
